/* hw/rtl/nls_pkg.sv */
package nls_pkg;

    localparam int XW    = 32;
    localparam int OW    = 32;
    localparam int STW   = 2;
    localparam int NW    = 10;
    localparam int IW    = NW + 1;
    localparam int XWW   = 48;
    localparam int DENW  = 48;
    localparam int NUMW  = 53;
    localparam int DVDW  = 85;
    localparam int QW    = 63;
    localparam int CNTW  = 7;
    localparam int SUMW  = 64;

    localparam logic [CNTW-1:0] WORK_STEPS  = 7'd85;
    localparam logic [CNTW-1:0] PLAIN_STEPS = 7'd33;

    localparam logic [QW-1:0]  QUOT_CAP = 63'h4000_0000_0000_0000;
    localparam logic [XWW-1:0] ONE      = 48'h0001_0000_0000;
    localparam logic [XW-1:0]  X_ONE    = 32'h0001_0000;
    localparam logic [NW-1:0]  TERMS_RESET = 10'd16;

    localparam logic [OW-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [OW-1:0] VAL_MIN = 32'h8000_0000;

    localparam logic [STW-1:0] ST_OK   = 2'd0;
    localparam logic [STW-1:0] ST_NINF = 2'd1;
    localparam logic [STW-1:0] ST_NAN  = 2'd2;
    localparam logic [STW-1:0] ST_SAT  = 2'd3;

    localparam logic CFG_METHOD = 1'b0;
    localparam logic CFG_TERMS  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLASS, S_P_WAIT, S_T_INIT, S_T_CHK, S_T_DIV, S_T_WAIT,
        S_Z_WAIT, S_Z2, S_CF_CHK, S_KK, S_KMUL, S_CF_DIV, S_CF_WAIT,
        S_M_DIV, S_M_WAIT, S_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_P_ONEMX, OP_P_Q, OP_T_INIT, OP_T_MUL, OP_T_ACC,
        OP_ZM_Q, OP_Z2, OP_DEN, OP_KK, OP_KMUL, OP_CF_Q, OP_MAG_Q, OP_MAG_SUM,
        OP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        DS_P, DS_Z, DS_T, DS_CF, DS_M
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        logic     div_start;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic special;
        logic method;
        logic neg;
        logic t_done;
        logic cf_more;
        logic den_bad;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* hw/rtl/nls_div.sv */
module nls_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     plain,
    input  logic [nls_pkg::NUMW-1:0] num,
    input  logic [nls_pkg::DENW-1:0] den,
    output logic                     done,
    output logic [nls_pkg::QW-1:0]   quot
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [nls_pkg::CNTW-1:0] cnt_reg, cnt_next;
    logic [nls_pkg::DVDW-1:0] dvd_reg, dvd_next;
    logic [nls_pkg::DENW-1:0] rem_reg, rem_next;
    logic [nls_pkg::DENW-1:0] den_reg, den_next;
    logic [nls_pkg::QW-1:0]   q_reg, q_next;
    logic                     ovf_reg, ovf_next;
    logic [nls_pkg::DENW:0]   rem_sh;
    logic [nls_pkg::DENW:0]   rem_sub;
    logic                     ge;

    assign rem_sh  = {rem_reg, dvd_reg[nls_pkg::DVDW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = rem_sh >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            ovf_next  = 1'b0;
            if (plain) begin
                dvd_next = {num[32:0], 52'd0};
                cnt_next = nls_pkg::PLAIN_STEPS;
            end else begin
                dvd_next = {num, 32'd0};
                cnt_next = nls_pkg::WORK_STEPS;
            end
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[nls_pkg::DVDW-2:0], 1'b0};
            rem_next = ge ? rem_sub[nls_pkg::DENW-1:0] : rem_sh[nls_pkg::DENW-1:0];
            q_next   = {q_reg[nls_pkg::QW-2:0], ge};
            ovf_next = ovf_reg | q_reg[nls_pkg::QW-1];
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign done = done_reg;
    assign quot = (ovf_reg || q_reg > nls_pkg::QUOT_CAP) ? nls_pkg::QUOT_CAP : q_reg;

endmodule

/* hw/rtl/nls_datapath.sv */
module nls_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [nls_pkg::NW-1:0]   cfg_wdata,
    input  logic [nls_pkg::XW-1:0]   s_x_value,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic [nls_pkg::OW-1:0]   m_log_value,
    output logic [nls_pkg::STW-1:0]  m_status,
    input  nls_pkg::dp_cmd_t         cmd,
    output nls_pkg::dp_stat_t        stat
);

    logic                      method_reg;
    logic [nls_pkg::NW-1:0]    terms_reg;
    logic [nls_pkg::XWW-1:0]   x_reg;
    logic                      special_reg;
    logic [nls_pkg::STW-1:0]   spec_reg;
    logic [31:0]               p_reg;
    logic [31:0]               zm_reg;
    logic [31:0]               z2_reg;
    logic [32:0]               pw_reg;
    logic [nls_pkg::SUMW-1:0]  sum_reg;
    logic [nls_pkg::IW-1:0]    idx_reg;
    logic [19:0]               kk_reg;
    logic [51:0]               num_reg;
    logic [nls_pkg::QW-1:0]    cf_reg;
    logic [nls_pkg::DENW-1:0]  den_reg;
    logic                      sat_reg;
    logic [nls_pkg::SUMW-1:0]  mag_reg;
    logic                      out_valid_reg;
    logic [nls_pkg::OW-1:0]    out_val_reg;
    logic [nls_pkg::STW-1:0]   out_st_reg;

    logic                      neg;
    logic [64:0]               pw_prod;
    logic [63:0]               zz_prod;
    logic [9:0]                k_val;
    logic [19:0]               kk_prod;
    logic [51:0]               num_prod;
    logic [11:0]               two_i_m1;
    logic [63:0]               den_top;
    logic [63:0]               den_calc;
    logic                      den_bad;
    logic [57:0]               om;
    logic [nls_pkg::OW-1:0]    fin_val;
    logic [nls_pkg::STW-1:0]   fin_st;
    logic                      div_done;
    logic [nls_pkg::QW-1:0]    div_q;
    logic                      div_plain;
    logic [nls_pkg::NUMW-1:0]  div_num;
    logic [nls_pkg::DENW-1:0]  div_den;

    assign neg      = x_reg < nls_pkg::ONE;
    assign pw_prod  = pw_reg * p_reg;
    assign zz_prod  = zm_reg * zm_reg;
    assign k_val    = idx_reg[9:0] - 10'd1;
    assign kk_prod  = k_val * k_val;
    assign num_prod = kk_reg * z2_reg;
    assign two_i_m1 = {idx_reg, 1'b0} - 12'd1;
    assign den_top  = (idx_reg > 11'd1) ? {20'd0, two_i_m1, 32'd0} : {16'd0, nls_pkg::ONE};
    assign den_calc = den_top - {1'b0, cf_reg};
    assign den_bad  = den_calc[63] || (den_calc == 64'd0);
    assign om       = mag_reg[63:6];

    always_comb begin
        div_plain = 1'b0;
        div_num   = '0;
        div_den   = den_reg;
        case (cmd.div_sel)
            nls_pkg::DS_P: begin
                div_num = {5'd0, x_reg - nls_pkg::ONE};
                div_den = x_reg;
            end
            nls_pkg::DS_Z: begin
                div_num = {5'd0, neg ? nls_pkg::ONE - x_reg : x_reg - nls_pkg::ONE};
                div_den = x_reg + nls_pkg::ONE;
            end
            nls_pkg::DS_T: begin
                div_plain = 1'b1;
                div_num   = {20'd0, pw_reg};
                div_den   = {37'd0, idx_reg};
            end
            nls_pkg::DS_CF: begin
                div_num = {1'b0, num_reg};
            end
            nls_pkg::DS_M: begin
                div_num = {20'd0, zm_reg, 1'b0};
            end
            default: begin
                div_num = '0;
            end
        endcase
    end

    nls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .plain   (div_plain),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        if (special_reg) begin
            fin_st  = spec_reg;
            fin_val = (spec_reg == nls_pkg::ST_NINF) ? nls_pkg::VAL_MIN : '0;
        end else if (neg) begin
            if (sat_reg || om > 58'h0_8000_0000) begin
                fin_val = nls_pkg::VAL_MIN;
                fin_st  = nls_pkg::ST_SAT;
            end else begin
                fin_val = 32'd0 - om[31:0];
                fin_st  = nls_pkg::ST_OK;
            end
        end else begin
            if (sat_reg || om > 58'h0_7FFF_FFFF) begin
                fin_val = nls_pkg::VAL_MAX;
                fin_st  = nls_pkg::ST_SAT;
            end else begin
                fin_val = om[31:0];
                fin_st  = nls_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg    <= 1'b0;
            terms_reg     <= nls_pkg::TERMS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    nls_pkg::CFG_METHOD: method_reg <= cfg_wdata[0];
                    nls_pkg::CFG_TERMS:  terms_reg  <= cfg_wdata;
                    default:             method_reg <= method_reg;
                endcase
            end
            if (cmd.op == nls_pkg::OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end

        case (cmd.op)
            nls_pkg::OP_ACCEPT: begin
                x_reg   <= {s_x_value, 16'd0};
                sat_reg <= 1'b0;
                mag_reg <= '0;
                if (s_x_value == '0) begin
                    special_reg <= 1'b1;
                    spec_reg    <= nls_pkg::ST_NINF;
                end else if (s_x_value[nls_pkg::XW-1]) begin
                    special_reg <= 1'b1;
                    spec_reg    <= nls_pkg::ST_NAN;
                end else if (s_x_value == nls_pkg::X_ONE) begin
                    special_reg <= 1'b1;
                    spec_reg    <= nls_pkg::ST_OK;
                end else begin
                    special_reg <= 1'b0;
                    spec_reg    <= nls_pkg::ST_OK;
                end
            end
            nls_pkg::OP_P_ONEMX: p_reg <= 32'(nls_pkg::ONE - x_reg);
            nls_pkg::OP_P_Q:     p_reg <= div_q[31:0];
            nls_pkg::OP_T_INIT: begin
                idx_reg <= 11'd1;
                pw_reg  <= nls_pkg::ONE[32:0];
                sum_reg <= '0;
            end
            nls_pkg::OP_T_MUL:   pw_reg <= pw_prod[64:32];
            nls_pkg::OP_T_ACC: begin
                sum_reg <= sum_reg + {1'b0, div_q};
                idx_reg <= idx_reg + 11'd1;
            end
            nls_pkg::OP_ZM_Q:    zm_reg <= div_q[31:0];
            nls_pkg::OP_Z2: begin
                z2_reg  <= zz_prod[63:32];
                idx_reg <= {1'b0, terms_reg};
                cf_reg  <= '0;
            end
            nls_pkg::OP_DEN: begin
                den_reg <= den_calc[nls_pkg::DENW-1:0];
                sat_reg <= den_bad;
            end
            nls_pkg::OP_KK:      kk_reg  <= kk_prod;
            nls_pkg::OP_KMUL:    num_reg <= num_prod;
            nls_pkg::OP_CF_Q: begin
                cf_reg  <= div_q;
                idx_reg <= idx_reg - 11'd1;
            end
            nls_pkg::OP_MAG_Q:   mag_reg <= {1'b0, div_q};
            nls_pkg::OP_MAG_SUM: mag_reg <= sum_reg;
            nls_pkg::OP_OUT: begin
                out_val_reg <= fin_val;
                out_st_reg  <= fin_st;
            end
            default: begin
                kk_reg <= kk_reg;
            end
        endcase
    end

    assign stat.special  = special_reg;
    assign stat.method   = method_reg;
    assign stat.neg      = neg;
    assign stat.t_done   = idx_reg > {1'b0, terms_reg};
    assign stat.cf_more  = idx_reg > 11'd1;
    assign stat.den_bad  = den_bad;
    assign stat.div_done = div_done;
    assign stat.out_free = !out_valid_reg || m_ready;

    assign m_valid     = out_valid_reg;
    assign m_log_value = out_val_reg;
    assign m_status    = out_st_reg;

endmodule

/* hw/rtl/nls_ctrl.sv */
module nls_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nls_pkg::dp_stat_t stat,
    output nls_pkg::dp_cmd_t  cmd
);

    nls_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nls_pkg::S_IDLE:    if (s_valid) state_next = nls_pkg::S_CLASS;
            nls_pkg::S_CLASS: begin
                if (stat.special) begin
                    state_next = nls_pkg::S_FIN;
                end else if (stat.method) begin
                    state_next = nls_pkg::S_Z_WAIT;
                end else if (stat.neg) begin
                    state_next = nls_pkg::S_T_INIT;
                end else begin
                    state_next = nls_pkg::S_P_WAIT;
                end
            end
            nls_pkg::S_P_WAIT:  if (stat.div_done) state_next = nls_pkg::S_T_INIT;
            nls_pkg::S_T_INIT:  state_next = nls_pkg::S_T_CHK;
            nls_pkg::S_T_CHK:   state_next = stat.t_done ? nls_pkg::S_FIN : nls_pkg::S_T_DIV;
            nls_pkg::S_T_DIV:   state_next = nls_pkg::S_T_WAIT;
            nls_pkg::S_T_WAIT:  if (stat.div_done) state_next = nls_pkg::S_T_CHK;
            nls_pkg::S_Z_WAIT:  if (stat.div_done) state_next = nls_pkg::S_Z2;
            nls_pkg::S_Z2:      state_next = nls_pkg::S_CF_CHK;
            nls_pkg::S_CF_CHK: begin
                if (stat.den_bad) begin
                    state_next = nls_pkg::S_FIN;
                end else if (stat.cf_more) begin
                    state_next = nls_pkg::S_KK;
                end else begin
                    state_next = nls_pkg::S_M_DIV;
                end
            end
            nls_pkg::S_KK:      state_next = nls_pkg::S_KMUL;
            nls_pkg::S_KMUL:    state_next = nls_pkg::S_CF_DIV;
            nls_pkg::S_CF_DIV:  state_next = nls_pkg::S_CF_WAIT;
            nls_pkg::S_CF_WAIT: if (stat.div_done) state_next = nls_pkg::S_CF_CHK;
            nls_pkg::S_M_DIV:   state_next = nls_pkg::S_M_WAIT;
            nls_pkg::S_M_WAIT:  if (stat.div_done) state_next = nls_pkg::S_FIN;
            nls_pkg::S_FIN:     if (stat.out_free) state_next = nls_pkg::S_IDLE;
            default:            state_next = nls_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.op        = nls_pkg::OP_NONE;
        cmd.div_start = 1'b0;
        cmd.div_sel   = nls_pkg::DS_P;
        case (state_reg)
            nls_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = nls_pkg::OP_ACCEPT;
            end
            nls_pkg::S_CLASS: begin
                if (!stat.special) begin
                    if (stat.method) begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = nls_pkg::DS_Z;
                    end else if (stat.neg) begin
                        cmd.op = nls_pkg::OP_P_ONEMX;
                    end else begin
                        cmd.div_start = 1'b1;
                        cmd.div_sel   = nls_pkg::DS_P;
                    end
                end
            end
            nls_pkg::S_P_WAIT:  if (stat.div_done) cmd.op = nls_pkg::OP_P_Q;
            nls_pkg::S_T_INIT:  cmd.op = nls_pkg::OP_T_INIT;
            nls_pkg::S_T_CHK: begin
                cmd.op = stat.t_done ? nls_pkg::OP_MAG_SUM : nls_pkg::OP_T_MUL;
            end
            nls_pkg::S_T_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = nls_pkg::DS_T;
            end
            nls_pkg::S_T_WAIT: begin
                cmd.div_sel = nls_pkg::DS_T;
                if (stat.div_done) cmd.op = nls_pkg::OP_T_ACC;
            end
            nls_pkg::S_Z_WAIT:  if (stat.div_done) cmd.op = nls_pkg::OP_ZM_Q;
            nls_pkg::S_Z2:      cmd.op = nls_pkg::OP_Z2;
            nls_pkg::S_CF_CHK:  cmd.op = nls_pkg::OP_DEN;
            nls_pkg::S_KK:      cmd.op = nls_pkg::OP_KK;
            nls_pkg::S_KMUL:    cmd.op = nls_pkg::OP_KMUL;
            nls_pkg::S_CF_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = nls_pkg::DS_CF;
            end
            nls_pkg::S_CF_WAIT: if (stat.div_done) cmd.op = nls_pkg::OP_CF_Q;
            nls_pkg::S_M_DIV: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = nls_pkg::DS_M;
            end
            nls_pkg::S_M_WAIT:  if (stat.div_done) cmd.op = nls_pkg::OP_MAG_Q;
            nls_pkg::S_FIN:     if (stat.out_free) cmd.op = nls_pkg::OP_OUT;
            default:            cmd.op = nls_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nls_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/natural_log_series_unit.sv */
// Computes ln(x) of a Q16.16 word in Q5.26 with a status code, one word at a time.
// Every quotient comes from a shared divider that resolves one bit per cycle.
// Zero, negative and one skip the divider. Taylor mode divides once per term,
// after first dividing (x-1)/x when x>1; continued-fraction mode divides for z,
// then once per term from n down to 2 (stopping early on a bad denominator)
// and once for the result, where n is term_count. A finished word waits in the
// output register while the next word is accepted.
module natural_log_series_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic                     cfg_index,
    input  logic [nls_pkg::NW-1:0]   cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [nls_pkg::XW-1:0]   s_x_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [nls_pkg::OW-1:0]   m_log_value,
    output logic [nls_pkg::STW-1:0]  m_status
);

    nls_pkg::dp_cmd_t  cmd;
    nls_pkg::dp_stat_t stat;

    nls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    nls_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_x_value   (s_x_value),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_log_value (m_log_value),
        .m_status    (m_status),
        .cmd         (cmd),
        .stat        (stat)
    );

    a_ninf_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == nls_pkg::ST_NINF |-> m_log_value == nls_pkg::VAL_MIN)
        else $error("minus infinity word carries a wrong value");

    a_nan_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == nls_pkg::ST_NAN |-> m_log_value == '0)
        else $error("not-a-number word carries a nonzero value");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == nls_pkg::ST_SAT |->
            m_log_value == nls_pkg::VAL_MIN || m_log_value == nls_pkg::VAL_MAX)
        else $error("saturated word is not at a limit");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in progress");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [nls_pkg::OW-1:0]  log_value;
        logic [nls_pkg::STW-1:0] status;
    } log_word_t;

    typedef struct {
        logic                    method;
        logic [nls_pkg::NW-1:0]  terms;
        logic [nls_pkg::XW-1:0]  x;
        logic                    typed;
        logic [nls_pkg::OW-1:0]  log_value;
        logic [nls_pkg::STW-1:0] status;
    } stim_row_t;

    localparam longint unsigned W_ONE = 64'd1 << 32;
    localparam longint unsigned W_CAP = 64'd1 << 62;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic                    cfg_index;
    logic [nls_pkg::NW-1:0]  cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic [nls_pkg::XW-1:0]  s_x_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [nls_pkg::OW-1:0]  m_log_value;
    logic [nls_pkg::STW-1:0] m_status;

    log_word_t pending_logs[$];
    logic      cur_method;
    logic [nls_pkg::NW-1:0] cur_terms;
    bit        calm;
    int        words_sent;
    int        words_checked;
    int        mismatches;
    int        saturated_seen;
    int        settings_used;

    natural_log_series_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_x_value   (s_x_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_log_value (m_log_value),
        .m_status    (m_status)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic longint unsigned work_div(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        longint unsigned res;
        q = num / den;
        r = num % den;
        if (q > (W_CAP >> 32))
            return W_CAP;
        res = q << 32;
        for (int b = 31; b >= 0; b--) begin
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                res = res | (64'd1 << b);
            end
        end
        return (res > W_CAP) ? W_CAP : res;
    endfunction

    function automatic longint unsigned series_sum(longint unsigned p, int n);
        longint unsigned pw;
        longint unsigned sum;
        pw = W_ONE;
        sum = 0;
        for (int i = 1; i <= n; i++) begin
            pw = (pw * p) >> 32;
            sum = sum + pw / i;
        end
        return sum;
    endfunction

    function automatic log_word_t predict_log(logic [nls_pkg::XW-1:0] raw, logic method,
                                              logic [nls_pkg::NW-1:0] terms);
        log_word_t       w;
        longint unsigned x;
        longint unsigned mag;
        longint unsigned om;
        longint unsigned zm;
        longint unsigned z2;
        longint unsigned cf;
        longint unsigned k;
        longint          den;
        bit              neg;
        bit              sat;
        int              n;
        n = terms;
        mag = 0;
        sat = 0;
        w.status = nls_pkg::ST_OK;
        if (raw == '0) begin
            w.log_value = nls_pkg::VAL_MIN;
            w.status = nls_pkg::ST_NINF;
            return w;
        end
        if (raw[nls_pkg::XW-1]) begin
            w.log_value = '0;
            w.status = nls_pkg::ST_NAN;
            return w;
        end
        x = longint'(raw) << 16;
        if (x == W_ONE) begin
            w.log_value = '0;
            return w;
        end
        neg = x < W_ONE;
        if (method == 1'b0) begin
            if (neg)
                mag = series_sum(W_ONE - x, n);
            else
                mag = series_sum(work_div(x - W_ONE, x), n);
        end else begin
            zm = work_div(neg ? W_ONE - x : x - W_ONE, x + W_ONE);
            z2 = (zm * zm) >> 32;
            cf = 0;
            for (int i = n; i > 1 && !sat; i--) begin
                k = i - 1;
                den = longint'(longint'(2 * i - 1) << 32) - longint'(cf);
                if (den <= 0)
                    sat = 1;
                else
                    cf = work_div(k * k * z2, den);
            end
            if (!sat) begin
                den = longint'(W_ONE) - longint'(cf);
                if (den <= 0)
                    sat = 1;
                else
                    mag = work_div(2 * zm, den);
            end
        end
        om = mag >> 6;
        if (neg) begin
            if (sat || om > 64'h8000_0000) begin
                w.log_value = nls_pkg::VAL_MIN;
                w.status = nls_pkg::ST_SAT;
            end else begin
                w.log_value = 32'd0 - om[31:0];
            end
        end else begin
            if (sat || om > 64'h7FFF_FFFF) begin
                w.log_value = nls_pkg::VAL_MAX;
                w.status = nls_pkg::ST_SAT;
            end else begin
                w.log_value = om[31:0];
            end
        end
        return w;
    endfunction

    task automatic drain_results();
        while (pending_logs.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apply_setting(logic method, logic [nls_pkg::NW-1:0] terms);
        drain_results();
        repeat (8) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= nls_pkg::CFG_METHOD;
        cfg_wdata <= nls_pkg::NW'(method);
        @(posedge aclk);
        cfg_index <= nls_pkg::CFG_TERMS;
        cfg_wdata <= terms;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_method = method;
        cur_terms = terms;
        settings_used++;
    endtask

    task automatic send_word(logic [nls_pkg::XW-1:0] x, bit typed, log_word_t typed_word);
        bit taken;
        while (!calm && $urandom_range(99) < 35) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_x_value <= x;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        pending_logs.push_back(typed ? typed_word : predict_log(x, cur_method, cur_terms));
        words_sent++;
    endtask

    function automatic logic [nls_pkg::XW-1:0] random_x();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return $urandom();
        else if (pick < 45)
            return nls_pkg::X_ONE + $urandom_range(16'hFFFF) - 32'h8000;
        else if (pick < 50)
            return (pick < 48) ? nls_pkg::X_ONE : '0;
        else
            return ($urandom() & 32'h7FFF_FFFF) >> $urandom_range(31);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= calm || ($urandom_range(99) >= 35);
    end

    always @(negedge aclk) begin
        log_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_logs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: log_value=%h status=%0d",
                             m_log_value, m_status);
            end else begin
                want = pending_logs.pop_front();
                words_checked++;
                if (m_status == nls_pkg::ST_SAT)
                    saturated_seen++;
                if (m_log_value !== want.log_value || m_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected log_value=%h status=%0d, got %h %0d",
                                 words_checked, want.log_value, want.status,
                                 m_log_value, m_status);
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        stim_row_t rows[$];
        log_word_t typed_word;
        logic      method;
        logic [nls_pkg::NW-1:0] terms;
        int        waited;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = nls_pkg::CFG_METHOD;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_x_value = '0;
        cur_method = 1'b0;
        cur_terms = nls_pkg::TERMS_RESET;
        calm = 0;
        words_sent = 0;
        words_checked = 0;
        mismatches = 0;
        saturated_seen = 0;
        settings_used = 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = '{
            '{1'b0, 10'd16,   32'h0000_0000, 1'b1, nls_pkg::VAL_MIN, nls_pkg::ST_NINF},
            '{1'b0, 10'd16,   32'h8000_0000, 1'b1, 32'h0,            nls_pkg::ST_NAN},
            '{1'b0, 10'd16,   32'hFFFF_FFFF, 1'b1, 32'h0,            nls_pkg::ST_NAN},
            '{1'b0, 10'd16,   nls_pkg::X_ONE, 1'b1, 32'h0,           nls_pkg::ST_OK},
            '{1'b0, 10'd16,   32'h0000_0001, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd16,   32'h7FFF_FFFF, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd16,   32'h0000_8000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd16,   32'h0002_0000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd16,   32'h0000_0000, 1'b1, nls_pkg::VAL_MIN, nls_pkg::ST_NINF},
            '{1'b1, 10'd16,   32'hFFFF_0000, 1'b1, 32'h0,            nls_pkg::ST_NAN},
            '{1'b1, 10'd16,   nls_pkg::X_ONE, 1'b1, 32'h0,           nls_pkg::ST_OK},
            '{1'b1, 10'd16,   32'h0000_0001, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd16,   32'h7FFF_FFFF, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd16,   32'h0002_8000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd0,    32'h0000_8000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd0,    32'h0003_0000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd0,    32'h0000_8000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd0,    32'h0003_0000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd1,    32'h0005_0000, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd1023, 32'h0000_0100, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b0, 10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd1023, 32'h0000_0100, 1'b0, 32'h0,            nls_pkg::ST_OK},
            '{1'b1, 10'd1023, 32'h7FFF_FFFF, 1'b0, 32'h0,            nls_pkg::ST_OK}
        };

        foreach (rows[r]) begin
            if (rows[r].method != cur_method || rows[r].terms != cur_terms) begin
                s_valid <= 1'b0;
                apply_setting(rows[r].method, rows[r].terms);
            end
            typed_word.log_value = rows[r].log_value;
            typed_word.status = rows[r].status;
            send_word(rows[r].x, rows[r].typed, typed_word);
        end

        for (int phase = 0; phase < 10; phase++) begin
            method = $urandom_range(1);
            terms = (phase == 9) ? 10'd1 : nls_pkg::NW'($urandom_range(8));
            s_valid <= 1'b0;
            apply_setting(method, terms);
            for (int i = 0; i < 100; i++) begin
                calm = (phase == 4);
                if (phase == 7 && i == 50) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    drain_results();
                end
                send_word(random_x(), 1'b0, typed_word);
            end
        end
        s_valid <= 1'b0;
        calm = 0;

        waited = 0;
        while (pending_logs.size() != 0 && waited < 400000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);

        $display("Sent %0d words over %0d register settings, both methods,",
                 words_sent, settings_used);
        $display("term counts 0 to 1023; checked %0d results, %0d saturated, %0d mismatches.",
                 words_checked, saturated_seen, mismatches);
        if (mismatches == 0 && pending_logs.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* natural_log_series_unit.f */
hw/rtl/nls_pkg.sv
hw/rtl/nls_div.sv
hw/rtl/nls_datapath.sv
hw/rtl/nls_ctrl.sv
hw/rtl/natural_log_series_unit.sv
verif/testbench.sv
